### rtl/core/cel_pkg.sv
// Shared types, character codes and token kinds for the expression lexer.
`default_nettype none

package cel_pkg;

  // Token kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_NUMBER = 4'd1,
    KIND_PLUS   = 4'd2,
    KIND_MINUS  = 4'd3,
    KIND_MUL    = 4'd4,
    KIND_DIV    = 4'd5,
    KIND_POW    = 4'd6,
    KIND_MOD    = 4'd7,
    KIND_LPAREN = 4'd8,
    KIND_RPAREN = 4'd9,
    KIND_ASSIGN = 4'd10,
    KIND_END    = 4'd11
  } kind_e;

  // Scanner mode; the fourth code is treated as idle.
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_e;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  // One result beat.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] int_part;
    logic [31:0] frac_part;
    logic [63:0] ident_chars;
    logic [7:0]  ident_length;
    logic        saturated;
    logic        last;
  } tok_t;

  // Tokens produced by one character, handed from the scanner to the queue.
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } push_t;

  // Operator decode result.
  typedef struct packed {
    logic  hit;
    kind_e kind;
  } op_t;

  function automatic op_t op_decode(input logic [7:0] c);
    op_t r;
    r.hit = 1'b1;
    case (c)
      CH_PLUS:   r.kind = KIND_PLUS;
      CH_MINUS:  r.kind = KIND_MINUS;
      CH_STAR:   r.kind = KIND_MUL;
      CH_SLASH:  r.kind = KIND_DIV;
      CH_CARET:  r.kind = KIND_POW;
      CH_PCT:    r.kind = KIND_MOD;
      CH_LPAREN: r.kind = KIND_LPAREN;
      CH_RPAREN: r.kind = KIND_RPAREN;
      CH_EQUAL:  r.kind = KIND_ASSIGN;
      default: begin
        r.hit  = 1'b0;
        r.kind = KIND_END;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/cel_scan.sv
// Scanner state and per-character token logic of the expression lexer.
`default_nettype none

module cel_scan
  import cel_pkg::*;
#(
  parameter int NAME_BYTES = 8,
  parameter int INT_BITS   = 32,
  parameter int FRAC_BITS  = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] ch_i,
  output push_t           push_o
);

  // Fraction digit weights: 0.1, then repeatedly divided by ten with rounding.
  localparam int WDEPTH = 16;
  localparam int WIDX_W = $clog2(WDEPTH);
  localparam int NAME_W = 8 * NAME_BYTES;

  function automatic logic [FRAC_BITS-1:0] weight_at(input int unsigned k);
    longint unsigned w;
    int unsigned     i;
    w = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
    for (i = 0; i < k; i++) begin
      w = (w + 64'd5) / 64'd10;
    end
    return w[FRAC_BITS-1:0];
  endfunction

  logic [FRAC_BITS-1:0] weight_tab [WDEPTH];

  for (genvar k = 0; k < WDEPTH; k++) begin : g_weight
    assign weight_tab[k] = weight_at(k);
  end

  // State registers.
  mode_e                mode_q, mode_d;
  logic [INT_BITS-1:0]  int_q, int_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic [WIDX_W-1:0]    widx_q, widx_d;
  logic                 point_q, point_d;
  logic                 ovf_q, ovf_d;
  logic [NAME_W-1:0]    name_q, name_d;
  logic [7:0]           cnt_q, cnt_d;

  // Character classes.
  logic is_dig, is_alp, is_spc, is_pt, is_nul;
  op_t  op;

  always_comb begin
    is_dig = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    is_alp = ((ch_i >= CH_LOW_A) && (ch_i <= CH_LOW_Z)) ||
             ((ch_i >= CH_UP_A) && (ch_i <= CH_UP_Z));
    is_spc = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));
    is_pt  = (ch_i == CH_POINT);
    is_nul = (ch_i == CH_NUL);
    op     = op_decode(ch_i);
  end

  // Decide whether the pending token continues, ends, or a new one starts.
  logic in_ident, in_num;
  logic cont_ident, cont_num, cont;
  logic start_ident, start_num;

  always_comb begin
    in_ident = 1'b0;
    in_num   = 1'b0;
    unique case (mode_q)
      MODE_IDENT:  in_ident = 1'b1;
      MODE_NUMBER: in_num   = 1'b1;
      default:     ;
    endcase
    cont_ident  = in_ident && (is_alp || is_dig);
    cont_num    = in_num && (is_dig || is_pt);
    cont        = cont_ident || cont_num;
    start_ident = !cont && is_alp;
    start_num   = !cont && (is_dig || is_pt);
  end

  // Number unit: one digit or point applied to the running or cleared value.
  logic [INT_BITS-1:0]  int_src;
  logic [FRAC_BITS-1:0] frac_src;
  logic [WIDX_W-1:0]    widx_src;
  logic                 point_src, ovf_src;
  logic [3:0]           digit;
  logic [INT_BITS+3:0]  int_sum;
  logic [FRAC_BITS+3:0] frac_sum;
  logic [INT_BITS-1:0]  int_upd;
  logic [FRAC_BITS-1:0] frac_upd;
  logic [WIDX_W-1:0]    widx_upd;
  logic                 point_upd, ovf_upd;

  always_comb begin
    int_src   = cont_num ? int_q   : '0;
    frac_src  = cont_num ? frac_q  : '0;
    widx_src  = cont_num ? widx_q  : '0;
    point_src = cont_num ? point_q : 1'b0;
    ovf_src   = cont_num ? ovf_q   : 1'b0;
    digit     = 4'(ch_i - CH_ZERO);

    int_sum  = (INT_BITS+4)'({4'b0, int_src} << 3) + (INT_BITS+4)'({4'b0, int_src} << 1) +
               (INT_BITS+4)'(digit);
    frac_sum = (FRAC_BITS+4)'({4'b0, frac_src}) +
               (FRAC_BITS+4)'(digit) * (FRAC_BITS+4)'(weight_tab[widx_src]);

    int_upd   = int_src;
    frac_upd  = frac_src;
    widx_upd  = widx_src;
    point_upd = point_src;
    ovf_upd   = ovf_src;
    if (is_pt) begin
      point_upd = 1'b1;
    end else if (!point_src) begin
      if (int_sum[INT_BITS+3:INT_BITS] != 4'd0) begin
        int_upd = '1;
        ovf_upd = 1'b1;
      end else begin
        int_upd = int_sum[INT_BITS-1:0];
      end
    end else begin
      if (frac_sum[FRAC_BITS+3:FRAC_BITS] != 4'd0) begin
        frac_upd = '1;
      end else begin
        frac_upd = frac_sum[FRAC_BITS-1:0];
      end
      if (widx_src != WIDX_W'(WDEPTH - 1)) begin
        widx_upd = widx_src + WIDX_W'(1);
      end
    end
  end

  // Name unit: append one character, truncating the stored bytes.
  logic [NAME_W-1:0] name_src, name_upd;
  logic [7:0]        cnt_src, cnt_upd;

  always_comb begin
    name_src = cont_ident ? name_q : '0;
    cnt_src  = cont_ident ? cnt_q  : 8'd0;
    name_upd = name_src;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (cnt_src == 8'(i)) begin
        name_upd[8*i +: 8] = ch_i;
      end
    end
    cnt_upd = (cnt_src == 8'hFF) ? cnt_src : cnt_src + 8'd1;
  end

  // Next state.
  always_comb begin
    mode_d  = mode_q;
    int_d   = int_q;
    frac_d  = frac_q;
    widx_d  = widx_q;
    point_d = point_q;
    ovf_d   = ovf_q;
    name_d  = name_q;
    cnt_d   = cnt_q;
    if (fire_i) begin
      if (cont_ident || start_ident) begin
        mode_d = MODE_IDENT;
      end else if (cont_num || start_num) begin
        mode_d = MODE_NUMBER;
      end else begin
        mode_d = MODE_IDLE;
      end
      if (cont_num || start_num) begin
        int_d   = int_upd;
        frac_d  = frac_upd;
        widx_d  = widx_upd;
        point_d = point_upd;
        ovf_d   = ovf_upd;
      end else begin
        int_d   = '0;
        frac_d  = '0;
        widx_d  = '0;
        point_d = 1'b0;
        ovf_d   = 1'b0;
      end
      if (cont_ident || start_ident) begin
        name_d = name_upd;
        cnt_d  = cnt_upd;
      end else begin
        name_d = '0;
        cnt_d  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      int_q   <= '0;
      frac_q  <= '0;
      widx_q  <= '0;
      point_q <= 1'b0;
      ovf_q   <= 1'b0;
      name_q  <= '0;
      cnt_q   <= 8'd0;
    end else begin
      mode_q  <= mode_d;
      int_q   <= int_d;
      frac_q  <= frac_d;
      widx_q  <= widx_d;
      point_q <= point_d;
      ovf_q   <= ovf_d;
      name_q  <= name_d;
      cnt_q   <= cnt_d;
    end
  end

  // Tokens for this character: the finished pending token, then an operator or end.
  tok_t pend_tok, sec_tok;
  logic pend_hit, sec_hit;

  always_comb begin
    pend_tok      = '0;
    pend_tok.kind = KIND_IDENT;
    pend_hit      = 1'b0;
    if (in_ident && !cont_ident) begin
      pend_hit                 = 1'b1;
      pend_tok.kind            = KIND_IDENT;
      pend_tok.ident_chars     = 64'(name_q);
      pend_tok.ident_length    = cnt_q;
    end else if (in_num && !cont_num) begin
      pend_hit           = 1'b1;
      pend_tok.kind      = KIND_NUMBER;
      pend_tok.int_part  = 32'(int_q);
      pend_tok.frac_part = 32'(frac_q) << (32 - FRAC_BITS);
      pend_tok.saturated = ovf_q;
    end

    sec_tok      = '0;
    sec_tok.kind = KIND_END;
    sec_hit      = 1'b0;
    if (!cont && is_nul) begin
      sec_hit      = 1'b1;
      sec_tok.last = 1'b1;
    end else if (!cont && op.hit) begin
      sec_hit      = 1'b1;
      sec_tok.kind = op.kind;
    end

    push_o.first  = pend_hit ? pend_tok : sec_tok;
    push_o.second = sec_tok;
    if (!fire_i) begin
      push_o.count = 2'd0;
    end else begin
      push_o.count = 2'(pend_hit) + 2'(sec_hit);
    end
  end

endmodule

`default_nettype wire

### rtl/core/cel_fifo.sv
// Four-entry token queue that takes up to two tokens per cycle.
`default_nettype none

module cel_fifo
  import cel_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  output tok_t       tok_o,
  output logic       valid_o,
  input  wire logic  ready_i
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  tok_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  // Output side.
  always_comb begin
    valid_o = (cnt_q != CNT_W'(0));
    tok_o   = mem_q[rd_q];
    pop     = valid_o && ready_i;
    room_o  = (cnt_q <= CNT_W'(DEPTH - 2));
  end

  // Pointer and fill count updates.
  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.count);
    rd_d  = pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage writes; the second token goes to the slot after the first.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.second;
    end
  end

endmodule

`default_nettype wire

### rtl/core/calculator_expression_lexer_top.sv
// Top level of the streaming arithmetic expression lexer.
//
//   Channel  Direction  Handshake                  Beat contents
//   ch       in         ch_valid_i / ch_ready_o    one character byte, 0 ends the string
//   tok      out        tok_valid_o / tok_ready_i  one token: kind, number, identifier, flags
//
// One character can be taken per cycle. A character waits in the input register
// until the queue has two free slots, is scanned in that cycle, and its tokens
// are written to the four-entry queue at the next edge, ready for the output.
// A pending identifier or number comes out only when a later character ends it.
// With three or more tokens queued the input stalls until the queue drains.
// Reset returns the scanner to idle with cleared number and name state.
`default_nettype none

module calculator_expression_lexer_top
  import cel_pkg::*;
#(
  parameter int NAME_BYTES = 8,
  parameter int INT_BITS   = 32,
  parameter int FRAC_BITS  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        ch_valid_i,
  output logic             ch_ready_o,
  input  wire logic [7:0]  ch_i,
  output logic             tok_valid_o,
  input  wire logic        tok_ready_i,
  output logic [3:0]       kind_o,
  output logic [31:0]      int_part_o,
  output logic [31:0]      frac_part_o,
  output logic [63:0]      ident_chars_o,
  output logic [7:0]       ident_length_o,
  output logic             saturated_o,
  output logic             last_o
);

  logic [7:0] ch_q, ch_d;
  logic       vld_q, vld_d;
  logic       room, fire, take;
  push_t      push;
  tok_t       tok;

  // Input register.
  always_comb begin
    fire       = vld_q && room;
    ch_ready_o = !vld_q || fire;
    take       = ch_valid_i && ch_ready_o;
    vld_d      = take ? 1'b1 : (fire ? 1'b0 : vld_q);
    ch_d       = take ? ch_i : ch_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
  end

  // Scanner.
  cel_scan #(
    .NAME_BYTES (NAME_BYTES),
    .INT_BITS   (INT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .ch_i   (ch_q),
    .push_o (push)
  );

  // Token queue.
  cel_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .tok_o   (tok),
    .valid_o (tok_valid_o),
    .ready_i (tok_ready_i)
  );

  // Output fields.
  always_comb begin
    kind_o         = tok.kind;
    int_part_o     = tok.int_part;
    frac_part_o    = tok.frac_part;
    ident_chars_o  = tok.ident_chars;
    ident_length_o = tok.ident_length;
    saturated_o    = tok.saturated;
    last_o         = tok.last;
  end

  // A held character stays in the input register until it is scanned.
  a_hold_ch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !fire |=> vld_q && $stable(ch_q))
    else $error("held character lost or changed");

  // Only the end token carries the last flag.
  a_last_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_o && last_o |-> kind_o == KIND_END)
    else $error("last flag on a token other than end");

  // Numeric fields are zero on every token that is not a number.
  a_num_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_o && kind_o != KIND_NUMBER |->
      int_part_o == 32'd0 && frac_part_o == 32'd0 && !saturated_o)
    else $error("numeric fields set on a non-number token");

  // The scanner never pushes into a queue without room for it.
  a_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |-> push.count == 2'd0)
    else $error("tokens pushed without a scanned character");

endmodule

`default_nettype wire
